// ===== src/downsampling_weighted_blur_2d_defines.svh =====
// Assertion macros used by the checker file.
`ifndef DOWNSAMPLING_WEIGHTED_BLUR_2D_DEFINES_SVH
`define DOWNSAMPLING_WEIGHTED_BLUR_2D_DEFINES_SVH
// Assert that a condition implies a consequence on the next edge.
`define DWB_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
	else $error(msg);
// Assert that a condition implies a consequence on the same edge.
`define DWB_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
	else $error(msg);
`endif

// ===== src/dwb_pkg.sv =====
// ------------------------------------------------------------------------
// dwb_pkg
// Constants and register indexes for the decimating weighted blur.
// ------------------------------------------------------------------------
package dwb_pkg;
	localparam int MAX_SIDE    = 256;
	localparam int SIDE_BITS   = $clog2(MAX_SIDE);
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_RADIUS  = 3;
	localparam int WEIGHT_BITS = 8;
	localparam int TAPS        = 2 * MAX_RADIUS + 1;
	localparam int ADDR_BITS   = 2 * SIDE_BITS;
	// 2 weights product, up to 49 of them
	localparam int SW_BITS     = 2 * WEIGHT_BITS + 6;
	localparam int SWV_BITS    = SW_BITS + SAMPLE_BITS;
	localparam int DEN_BITS    = SW_BITS + 16;
	localparam int CFG_BITS    = 56;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_RADIUS = 3'd2;
	localparam logic [2:0] REG_STRIDE = 3'd3;
	localparam logic [2:0] REG_IN_MAX = 3'd4;
	localparam logic [2:0] REG_OUT_MAX = 3'd5;
	localparam logic [2:0] REG_TAPS   = 3'd6;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
endpackage

// ===== src/downsampling_weighted_blur_2d.sv =====
// ------------------------------------------------------------------------
// downsampling_weighted_blur_2d
// Image memory with a decimating separable weighted-mean query.
// ------------------------------------------------------------------------
// channel  | handshake             | payload
// request  | start / busy          | req_type, pos_x, pos_y, pixel_value
// result   | done (one cycle)      | blurred_value, no_support
// config   | cfg_we                | cfg_index, cfg_data
//
// A write never raises busy. A query holds busy through the (2r+1)^2 scan
// steps through the single read port, a drain state for the read latency, a
// state to form the divisor, the divider steps and an output state; done
// rises as busy drops. A query with in_max zero goes straight to the output
// state. Reset returns the registers to their defaults; the image memory is
// undefined until written.
// The receiver cannot stall results.
module downsampling_weighted_blur_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [15:0] pixel_value,
	output logic        done,
	output logic [15:0] blurred_value,
	output logic        no_support,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [55:0] cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [8:0]  width_q, height_q;
	logic [1:0]  radius_q;
	logic [2:0]  stride_q;
	logic [15:0] in_max_q, out_max_q;
	logic [55:0] taps_q;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= 9'd256;
			height_q  <= 9'd256;
			radius_q  <= 2'd1;
			stride_q  <= 3'd1;
			in_max_q  <= 16'd255;
			out_max_q <= 16'd255;
			taps_q    <= 56'h01010101010101;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dwb_pkg::REG_WIDTH:   width_q   <= cfg_data[8:0];
				dwb_pkg::REG_HEIGHT:  height_q  <= cfg_data[8:0];
				dwb_pkg::REG_RADIUS:  radius_q  <= cfg_data[1:0];
				dwb_pkg::REG_STRIDE:  stride_q  <= cfg_data[2:0];
				dwb_pkg::REG_IN_MAX:  in_max_q  <= cfg_data[15:0];
				dwb_pkg::REG_OUT_MAX: out_max_q <= cfg_data[15:0];
				dwb_pkg::REG_TAPS:    taps_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [15:0] mem [dwb_pkg::MAX_SIDE * dwb_pkg::MAX_SIDE];
	logic [15:0] rdata_s2;

	logic [2:0]  state_q;
	logic [10:0] cx_q, cy_q;
	logic [2:0]  dx_q, dy_q;
	logic [1:0]  rr_q;
	// stage-1 window tap info, carried with the memory read
	logic        vld_s1;
	logic [15:0] wt_s1;
	logic [dwb_pkg::SW_BITS-1:0]  sw_q;
	logic [dwb_pkg::SWV_BITS-1:0] swv_q;
	logic [dwb_pkg::DEN_BITS-1:0] den_q;
	logic [dwb_pkg::DEN_BITS-1:0] rem_q;
	logic [16:0] mult_q;
	logic [15:0] quo_q;
	logic [4:0]  bit_q;
	logic        sat_q, zero_q;

	// Clamp the image size to the store side
	logic [8:0]  w_lim, h_lim;
	assign w_lim = (width_q > 9'd256) ? 9'd256 : width_q;
	assign h_lim = (height_q > 9'd256) ? 9'd256 : height_q;

	// Window pixel position for the current tap
	logic signed [12:0] jx, jy;
	logic        in_img;
	logic [7:0]  wx, wy;
	logic [15:0] wt;
	assign jx = $signed({2'b0, cx_q}) - $signed({11'b0, rr_q}) + $signed({10'b0, dx_q});
	assign jy = $signed({2'b0, cy_q}) - $signed({11'b0, rr_q}) + $signed({10'b0, dy_q});
	assign in_img = (jx >= 0) && (jy >= 0) && (jx < $signed({4'b0, w_lim}))
		&& (jy < $signed({4'b0, h_lim}));
	assign wx = taps_q[dx_q * 8 +: 8];
	assign wy = taps_q[dy_q * 8 +: 8];
	assign wt = wx * wy;

	logic [dwb_pkg::ADDR_BITS-1:0] raddr;
	assign raddr = {jy[7:0], jx[7:0]};

	// Write or read the image memory
	always_ff @(posedge clk) begin
		if (start && !busy && req_type == dwb_pkg::REQ_WRITE)
			mem[{pos_y, pos_x}] <= pixel_value;
		rdata_s2 <= mem[raddr];
	end

	// One divider step: the partial remainder may pass the divisor twice
	logic [dwb_pkg::DEN_BITS+1:0] trial, den1, den2, diff1, diff2;
	assign trial = {1'b0, rem_q, 1'b0} + (mult_q[16] ? {2'b0, swv_q} : '0);
	assign den1 = {2'b0, den_q};
	assign den2 = {1'b0, den_q, 1'b0};
	assign diff1 = trial - den1;
	assign diff2 = trial - den2;

	assign busy = (state_q != ST_IDLE);

	// Sequence scan, accumulate and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && req_type == dwb_pkg::REQ_QUERY) begin
						cx_q <= {3'b0, pos_x} * stride_q;
						cy_q <= {3'b0, pos_y} * stride_q;
						rr_q <= radius_q;
						dx_q <= 3'd0;
						dy_q <= 3'd0;
						sw_q <= '0;
						swv_q <= '0;
						if (in_max_q == 16'd0) begin
							blurred_value <= 16'd0;
							no_support <= 1'b0;
							state_q <= ST_OUT;
						end else
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= in_img && (wt != 16'd0);
					wt_s1 <= wt;
					if (dx_q == {rr_q, 1'b0}) begin
						dx_q <= 3'd0;
						if (dy_q == {rr_q, 1'b0})
							state_q <= ST_DRAIN;
						else
							dy_q <= dy_q + 3'd1;
					end else
						dx_q <= dx_q + 3'd1;
				end
				ST_DRAIN: state_q <= ST_PREP;
				ST_PREP: begin
					den_q <= sw_q * in_max_q;
					state_q <= ST_DIV;
					bit_q <= 5'd0;
				end
				ST_DIV: begin
					if (bit_q == 5'd0) begin
						zero_q <= (sw_q == '0);
						sat_q <= (swv_q >= den_q);
						rem_q <= '0;
						quo_q <= '0;
						mult_q <= {1'b0, out_max_q} + 17'd1;
						bit_q <= 5'd1;
					end else begin
						mult_q <= {mult_q[15:0], 1'b0};
						if (trial >= den2) begin
							rem_q <= diff2[dwb_pkg::DEN_BITS-1:0];
							quo_q <= {quo_q[14:0], 1'b0} + 16'd2;
						end else if (trial >= den1) begin
							rem_q <= diff1[dwb_pkg::DEN_BITS-1:0];
							quo_q <= {quo_q[14:0], 1'b1};
						end else begin
							rem_q <= trial[dwb_pkg::DEN_BITS-1:0];
							quo_q <= {quo_q[14:0], 1'b0};
						end
						if (bit_q == 5'd17) state_q <= ST_OUT;
						bit_q <= bit_q + 5'd1;
					end
				end
				ST_OUT: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
					if (in_max_q != 16'd0) begin
						no_support <= zero_q;
						if (zero_q) blurred_value <= 16'd0;
						else if (sat_q || quo_q > out_max_q) blurred_value <= out_max_q;
						else blurred_value <= quo_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Accumulate each read in the cycle after its address
			if (vld_s1) begin
				sw_q <= sw_q + {6'b0, wt_s1};
				swv_q <= swv_q + wt_s1 * rdata_s2;
			end
		end
	end
endmodule

// ===== src/dwb_checker.sv =====
// ------------------------------------------------------------------------
// dwb_checker
// Port-level checks for the blur block, bound to the top level.
// ------------------------------------------------------------------------
`include "downsampling_weighted_blur_2d_defines.svh"
module dwb_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic req_type,
	input logic done,
	input logic no_support,
	input logic [15:0] blurred_value
);
	`DWB_ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && req_type, busy, "query not taken")
	`DWB_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result held two cycles")
	`DWB_ASSERT_NOW(a_nosup_zero, clk, arst_n, done && no_support, blurred_value == 16'd0, "flag with value")
	`DWB_ASSERT_NEXT(a_write_idle, clk, arst_n, start && !busy && !req_type, !busy && !done, "write made work")
endmodule

bind downsampling_weighted_blur_2d dwb_checker u_dwb_checker (.*);
